@@ design/prfl_pkg.sv @@
// prfl_pkg: shared constants, codes and types of the page range free list
// used by prfl_cell and page_range_free_list_top; no dependencies
`default_nettype none

package prfl_pkg;

	localparam int MAX_RANGES_DEF = 64;
	localparam int ADDR_WIDTH_DEF = 48;

	localparam int OP_W       = 2;
	localparam int ADDR_IN_W  = 48;
	localparam int PAGES_W    = 36;
	localparam int PAGE_SHIFT = 12;
	localparam int TDATA_W    = 88;
	localparam int CAP_W      = 7;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [CAP_W-1:0]   CAP_RESET    = 7'd64;
	localparam logic [PADDR_W-1:0] REG_CAPACITY = 3'd0;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_MERGE = 2'd1,
		OP_ALLOC = 2'd2,
		OP_TAKE  = 2'd3
	} op_t;

	// broadcast control for the row of cells
	typedef struct packed {
		logic rotate;
		logic compact;
		logic append;
	} cell_ctl_t;

	function automatic logic [PAGES_W-1:0] sat_add(input logic [PAGES_W-1:0] a,
			input logic [PAGES_W-1:0] b);
		logic [PAGES_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[PAGES_W] ? {PAGES_W{1'b1}} : sum[PAGES_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ design/page_range_free_list_top.sv @@
// page_range_free_list_top: first-fit free list of page ranges on a ring of cells
// depends on prfl_pkg and prfl_cell
//
// requests enter on s_t* (s_tuser: operation; s_tdata: address, page_count),
// one result leaves per request on m_t* (m_tuser: success;
// m_tdata: result_address, result_pages). capacity_limit sits on the
// apb-style port at byte address 0.
// add goes from acceptance straight to the fix state, then the done state,
// then the output register. add-merge, allocate and take-range rotate the
// whole ring of MAX_RANGES cells once past the head cell, which checks and
// rewrites one entry a cycle, then close the gap or append in the fix state.
// one request is in work at a time; the next is accepted once the result
// has moved into the output register, so a waiting result does not block it.
// if the receiver stalls, the finished result waits in the block and no
// new request is taken until the output register frees.
// reset empties the table and sets capacity_limit to 64; no clearing pass.
`default_nettype none

module page_range_free_list_top
	import prfl_pkg::*;
#(
	parameter int MAX_RANGES = MAX_RANGES_DEF,
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	output logic               s_tready,
	input  wire [TDATA_W-1:0]  s_tdata,  // address, page_count, zero pad
	input  wire [OP_W-1:0]     s_tuser,  // operation
	output logic               m_tvalid,
	input  wire                m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // result_address, result_pages, zero pad
	output logic               m_tuser,  // success
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [PADDR_W-1:0]  paddr,
	input  wire [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int IDX_W = $clog2(MAX_RANGES);
	localparam int CNT_W = $clog2(MAX_RANGES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RANGES - 1);
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_RANGES);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_FIX  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [CAP_W-1:0]      cap_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      k_q;
	logic [IDX_W-1:0]      idx_q;
	op_t                   op_q;
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [ADDR_WIDTH-1:0] next_q;
	logic [ADDR_WIDTH-1:0] pg_off_q;
	logic [PAGES_W-1:0]    pages_q;
	logic                  found_q;
	logic                  del_q;
	logic                  ok_q;
	logic [ADDR_WIDTH-1:0] raddr_q;
	logic [PAGES_W-1:0]    rpages_q;
	logic                  m_tvalid_q;
	logic [TDATA_W-1:0]    m_tdata_q;
	logic                  m_tuser_q;

	logic [ADDR_WIDTH-1:0] base_w [MAX_RANGES];
	logic [PAGES_W-1:0]    size_w [MAX_RANGES];

	logic [ADDR_WIDTH-1:0] in_addr;
	logic [ADDR_WIDTH-1:0] in_off;
	logic [ADDR_WIDTH-1:0] head_base;
	logic [PAGES_W-1:0]    head_size;
	logic [ADDR_WIDTH-1:0] tail_base;
	logic [PAGES_W-1:0]    tail_size;
	logic                  live;
	logic                  hit;
	logic                  alloc_eq;
	logic                  pages_nz;
	logic                  space;
	logic                  do_append;
	logic                  out_free;
	cell_ctl_t             ctl;
	logic [IDX_W-1:0]      sel_idx;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// request decode
	assign in_addr = ADDR_WIDTH'(64'(s_tdata[ADDR_IN_W-1:0]));
	assign in_off  = ADDR_WIDTH'(64'(s_tdata[ADDR_IN_W +: PAGES_W]) << PAGE_SHIFT);

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// head cell check and rewrite
	assign head_base = base_w[0];
	assign head_size = size_w[0];
	assign pages_nz  = (pages_q != '0);
	assign alloc_eq  = (head_size == pages_q);
	assign live      = !found_q && (CNT_W'(k_q) < count_q);
	assign space     = (32'(count_q) < 32'(cap_q)) && (count_q < MAX_CNT);
	assign do_append = pages_nz && space && !found_q
		&& (op_q == OP_ADD || op_q == OP_MERGE);

	always_comb begin
		hit       = 1'b0;
		tail_base = head_base;
		tail_size = head_size;
		case (op_q)
			OP_MERGE: begin
				hit = live && pages_nz && (head_base == next_q);
				if (hit) begin
					tail_base = addr_q;
					tail_size = sat_add(head_size, pages_q);
				end
			end
			OP_ALLOC: begin
				hit = live && (head_size >= pages_q);
				if (hit && !alloc_eq) begin
					tail_base = head_base + pg_off_q;
					tail_size = head_size - pages_q;
				end
			end
			OP_TAKE: begin
				hit = live && (head_base == addr_q);
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	assign ctl.rotate  = (state_q == ST_SCAN);
	assign ctl.compact = (state_q == ST_FIX) && del_q;
	assign ctl.append  = (state_q == ST_FIX) && do_append;
	assign sel_idx     = del_q ? idx_q : count_q[IDX_W-1:0];

	// ring of cells, head at index 0, tail fed from the head
	for (genvar j = 0; j < MAX_RANGES; j++) begin : g_cell
		logic [ADDR_WIDTH-1:0] nb;
		logic [PAGES_W-1:0]    ns;
		if (j == MAX_RANGES - 1) begin : g_tail
			assign nb = tail_base;
			assign ns = tail_size;
		end else begin : g_mid
			assign nb = base_w[j+1];
			assign ns = size_w[j+1];
		end
		prfl_cell #(
			.ADDR_WIDTH (ADDR_WIDTH),
			.IDX_W      (IDX_W),
			.CELL_IDX   (j)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.sel_idx  (sel_idx),
			.nxt_base (nb),
			.nxt_size (ns),
			.new_base (addr_q),
			.new_size (pages_q),
			.base     (base_w[j]),
			.size     (size_w[j])
		);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			k_q        <= '0;
			found_q    <= 1'b0;
			del_q      <= 1'b0;
			ok_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						k_q     <= '0;
						found_q <= 1'b0;
						del_q   <= 1'b0;
						state_q <= (op_t'(s_tuser) == OP_ADD) ? ST_FIX : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
						del_q   <= (op_q == OP_TAKE) || (op_q == OP_ALLOC && alloc_eq);
					end
					k_q <= k_q + 1'b1;
					if (k_q == LAST_IDX) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					ok_q <= found_q || do_append;
					if (del_q) begin
						count_q <= count_q - 1'b1;
					end else if (do_append) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// request payload and results
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q     <= op_t'(s_tuser);
			addr_q   <= in_addr;
			pages_q  <= s_tdata[ADDR_IN_W +: PAGES_W];
			pg_off_q <= in_off;
			next_q   <= in_addr + in_off;
			raddr_q  <= '0;
			rpages_q <= '0;
		end else if (state_q == ST_SCAN && hit) begin
			idx_q <= k_q;
			if (op_q == OP_ALLOC) begin
				raddr_q <= head_base;
			end
			if (op_q == OP_TAKE) begin
				rpages_q <= head_size;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {(TDATA_W - ADDR_IN_W - PAGES_W)'(0), rpages_q,
				ADDR_IN_W'(64'(raddr_q))};
			m_tuser_q <= ok_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

@@ design/prfl_cell.sv @@
// prfl_cell: one table slot holding a range base and page count
// depends on prfl_pkg; takes its neighbour's entry on rotate or compact
`default_nettype none

module prfl_cell
	import prfl_pkg::*;
#(
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF,
	parameter int IDX_W      = 6,
	parameter int CELL_IDX   = 0
) (
	input  wire                   clk,
	input  cell_ctl_t             ctl,
	input  wire [IDX_W-1:0]       sel_idx,
	input  wire [ADDR_WIDTH-1:0]  nxt_base,
	input  wire [PAGES_W-1:0]     nxt_size,
	input  wire [ADDR_WIDTH-1:0]  new_base,
	input  wire [PAGES_W-1:0]     new_size,
	output logic [ADDR_WIDTH-1:0] base,
	output logic [PAGES_W-1:0]    size
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [ADDR_WIDTH-1:0] base_q;
	logic [PAGES_W-1:0]    size_q;

	always_ff @(posedge clk) begin
		if (ctl.rotate || (ctl.compact && MY_IDX >= sel_idx)) begin
			base_q <= nxt_base;
			size_q <= nxt_size;
		end else if (ctl.append && MY_IDX == sel_idx) begin
			base_q <= new_base;
			size_q <= new_size;
		end
	end

	assign base = base_q;
	assign size = size_q;

endmodule

`default_nettype wire
